/* rtl/egd_pkg.sv */
// egd_pkg: shared types and constants for the elias gamma/delta codec
// no dependencies; used by rtl/elias_gamma_delta_codec.sv
`timescale 1ns / 1ps

package egd_pkg;

	localparam int CHUNK_W     = 64;
	localparam int CNT_W       = 7;
	localparam int MAX_CHUNKS  = 3;
	localparam int DVAL_W      = 64;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 136;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;
	localparam logic KIND_GAMMA = 1'b0;
	localparam logic KIND_DELTA = 1'b1;

	localparam logic REG_DIRECTION = 1'b0;
	localparam logic REG_CODE_KIND = 1'b1;

	typedef struct packed {
		logic [CHUNK_W-1:0] bits;
		logic [CNT_W-1:0]   cnt;
	} chunk_t;

endpackage

/* rtl/elias_gamma_delta_codec.sv */
// elias_gamma_delta_codec: gamma-like / delta integer encoder and bit-serial decoder
// path: an accepted item passes the input register, the second stage and the result buffer in order
// throughput: one item per cycle while the output port accepts; an encode item of two or three chunks holds the
// output port for that many transfers, set by the three-entry chunk buffer
// reset: arst_n clears all control state asynchronously, no clearing pass
// depends on rtl/egd_pkg.sv
`timescale 1ns / 1ps

module elias_gamma_delta_codec #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// apb configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	// input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [egd_pkg::IN_TDATA_W-1:0]     s_tdata,  // value[63:0], in_bit[64], zero pad
	// result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [egd_pkg::OUT_TDATA_W-1:0]    m_tdata,  // code_bits[63:0], bit_count[70:64],
	                                                     // decoded_value[134:71], error[135]
	output logic                               m_tlast
);

	localparam int W   = VALUE_WIDTH;
	localparam int ZW  = $clog2(W + 1);
	localparam int LLW = $clog2(W + 2);
	localparam int PW  = 2 * LLW + 1;
	localparam int TW  = 2 * W + 1;
	localparam int NW  = $clog2(TW + 1);
	localparam int EW  = egd_pkg::MAX_CHUNKS * egd_pkg::CHUNK_W;
	localparam int CW  = egd_pkg::CHUNK_W;
	localparam int KW  = egd_pkg::CNT_W;

	localparam logic [1:0] PH_ONES = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_VAL  = 2'd2;

	// configuration
	logic dir_q;
	logic kind_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = {31'b0, (paddr[2] == egd_pkg::REG_CODE_KIND) ? kind_q : dir_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= egd_pkg::DIR_ENCODE;
			kind_q <= egd_pkg::KIND_DELTA;
		end else if (cfg_wr) begin
			if (paddr[2] == egd_pkg::REG_DIRECTION) begin
				dir_q <= pwdata[0];
			end else begin
				kind_q <= pwdata[0];
			end
		end
	end

	// flow control
	logic valid_s1, valid_s2, buf_valid_q;
	logic s1_go, s2_go, s2_ready, s2_has_res, buf_free, ld_buf, m_fire;

	assign m_fire     = m_tvalid && m_tready;
	assign buf_free   = !buf_valid_q || (m_fire && m_tlast);
	assign ld_buf     = valid_s2 && s2_has_res && buf_free;
	assign s2_go      = valid_s2 && (!s2_has_res || buf_free);
	assign s2_ready   = !valid_s2 || s2_go;
	assign s1_go      = valid_s1 && s2_ready;
	assign s_tready   = !valid_s1 || s1_go;

	// input register
	logic [egd_pkg::DVAL_W-1:0] value_s1;
	logic                       bit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			value_s1 <= s_tdata[egd_pkg::DVAL_W-1:0];
			bit_s1   <= s_tdata[egd_pkg::DVAL_W];
		end
	end

	// encoder: bit length, code word and its length
	logic [W-1:0]   v;
	logic [ZW-1:0]  z;
	logic [LLW-1:0] len_l, zl;
	logic [W-1:0]   ones_z;
	logic [LLW-1:0] ones_l;
	logic [PW-1:0]  pref;
	logic [TW-1:0]  t_d;
	logic [NW-1:0]  n_d;

	always_comb begin
		v = value_s1[W-1:0];
		z = ZW'(1);
		for (int i = 0; i < W; i++) begin
			if (v[i]) begin
				z = ZW'(i + 1);
			end
		end
		len_l = LLW'({1'b0, z}) + LLW'(1);
		zl = LLW'(1);
		for (int i = 0; i < LLW; i++) begin
			if (len_l[i]) begin
				zl = LLW'(i + 1);
			end
		end
		ones_z = {W{1'b1}} >> ((ZW + 1)'(W) - {1'b0, z});
		ones_l = {LLW{1'b1}} >> ((LLW + 1)'(LLW) - {1'b0, zl});
		pref   = (PW'(ones_l) << ({1'b0, zl} + (LLW + 1)'(1))) | PW'(len_l);
		if (kind_q == egd_pkg::KIND_DELTA) begin
			t_d = (TW'(pref) << z) | TW'(v);
			n_d = NW'({zl, 1'b1}) + NW'(z);
		end else begin
			t_d = (TW'(ones_z) << ({1'b0, z} + (ZW + 1)'(1))) | TW'(v);
			n_d = NW'({z, 1'b1});
		end
	end

	// decoder state
	logic [1:0]     phase_q, d_phase;
	logic [ZW-1:0]  ones_q, d_ones;
	logic [ZW-1:0]  left_q, d_left;
	logic [LLW-1:0] lenf_q, d_lenf;
	logic [W-1:0]   acc_q, d_acc;
	logic           d_res, d_err, d_clear, st;
	logic [ZW-1:0]  st_len, left_m1;
	logic [LLW-1:0] lf_n;
	logic [W-1:0]   acc_n, d_val;
	logic [ZW:0]    limit;

	always_comb begin
		d_phase = phase_q;
		d_ones  = ones_q;
		d_left  = left_q;
		d_lenf  = lenf_q;
		d_acc   = acc_q;
		d_res   = 1'b0;
		d_err   = 1'b0;
		d_val   = '0;
		d_clear = 1'b0;
		st      = 1'b0;
		st_len  = '0;
		left_m1 = left_q - ZW'(1);
		lf_n    = {lenf_q[LLW-2:0], bit_s1};
		acc_n   = {acc_q[W-2:0], bit_s1};
		limit   = (kind_q == egd_pkg::KIND_DELTA) ? (ZW + 1)'(LLW) : (ZW + 1)'(W);
		unique case (phase_q)
			PH_ONES: begin
				if (bit_s1) begin
					if ({1'b0, ones_q} + (ZW + 1)'(1) > limit) begin
						d_res   = 1'b1;
						d_err   = 1'b1;
						d_clear = 1'b1;
					end else begin
						d_ones = ones_q + ZW'(1);
					end
				end else if (kind_q == egd_pkg::KIND_GAMMA) begin
					st     = 1'b1;
					st_len = ones_q;
				end else if (ones_q == '0) begin
					d_res   = 1'b1;
					d_err   = 1'b1;
					d_clear = 1'b1;
				end else begin
					d_phase = PH_LEN;
					d_left  = ones_q;
					d_lenf  = '0;
				end
			end
			PH_LEN: begin
				if (left_m1 != '0) begin
					d_lenf = lf_n;
					d_left = left_m1;
				end else if (lf_n == '0 || (LLW + 1)'(lf_n) > (LLW + 1)'(W + 1)) begin
					d_res   = 1'b1;
					d_err   = 1'b1;
					d_clear = 1'b1;
				end else begin
					st     = 1'b1;
					st_len = ZW'(lf_n - LLW'(1));
				end
			end
			PH_VAL: begin
				if (left_m1 != '0) begin
					d_acc  = acc_n;
					d_left = left_m1;
				end else begin
					d_res   = 1'b1;
					d_val   = acc_n;
					d_clear = 1'b1;
				end
			end
			default: begin
				d_clear = 1'b1;
			end
		endcase
		if (st) begin
			if (st_len == '0) begin
				d_res   = 1'b1;
				d_clear = 1'b1;
			end else begin
				d_phase = PH_VAL;
				d_left  = st_len;
				d_acc   = '0;
			end
		end
		if (d_clear) begin
			d_phase = PH_ONES;
			d_ones  = '0;
			d_left  = '0;
			d_lenf  = '0;
			d_acc   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ONES;
			ones_q  <= '0;
			left_q  <= '0;
			lenf_q  <= '0;
			acc_q   <= '0;
		end else if (cfg_wr) begin
			phase_q <= PH_ONES;
			ones_q  <= '0;
			left_q  <= '0;
			lenf_q  <= '0;
			acc_q   <= '0;
		end else if (s1_go && dir_q == egd_pkg::DIR_DECODE) begin
			phase_q <= d_phase;
			ones_q  <= d_ones;
			left_q  <= d_left;
			lenf_q  <= d_lenf;
			acc_q   <= d_acc;
		end
	end

	// second stage: code word or decode result
	logic          enc_s2, dres_s2, derr_s2;
	logic [TW-1:0] t_s2;
	logic [NW-1:0] n_s2;
	logic [W-1:0]  dval_s2;

	assign s2_has_res = enc_s2 || dres_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			enc_s2  <= (dir_q == egd_pkg::DIR_ENCODE);
			dres_s2 <= d_res;
			derr_s2 <= d_err;
			dval_s2 <= d_val;
			t_s2    <= t_d;
			n_s2    <= n_d;
		end
	end

	// chunk split
	function automatic logic [CW-1:0] low_mask(input logic [KW-1:0] k);
		return {CW{1'b1}} >> (KW'(CW) - k);
	endfunction

	logic [EW-1:0]     te, fa, fb;
	logic [7:0]        nx, sha, shb;
	logic [KW-1:0]     ka, kb;
	egd_pkg::chunk_t   c_d [egd_pkg::MAX_CHUNKS];
	logic [1:0]        nch_d;

	always_comb begin
		te  = EW'(t_s2);
		nx  = 8'(n_s2);
		sha = nx - 8'd64;
		shb = nx - 8'd128;
		ka  = KW'(sha);
		kb  = KW'(shb);
		fa  = te >> sha;
		fb  = te >> shb;
		for (int i = 0; i < egd_pkg::MAX_CHUNKS; i++) begin
			c_d[i] = '0;
		end
		nch_d = 2'd1;
		if (enc_s2) begin
			if (nx <= 8'(CW)) begin
				c_d[0] = '{bits: te[CW-1:0], cnt: KW'(nx)};
			end else if (nx <= 8'(2 * CW)) begin
				c_d[0] = '{bits: fa[CW-1:0], cnt: KW'(CW)};
				c_d[1] = '{bits: te[CW-1:0] & low_mask(ka), cnt: ka};
				nch_d  = 2'd2;
			end else begin
				c_d[0] = '{bits: fa[CW-1:0], cnt: KW'(CW)};
				c_d[1] = '{bits: fb[CW-1:0], cnt: KW'(CW)};
				c_d[2] = '{bits: te[CW-1:0] & low_mask(kb), cnt: kb};
				nch_d  = 2'd3;
			end
		end
	end

	// result buffer
	egd_pkg::chunk_t            bch_q [egd_pkg::MAX_CHUNKS];
	logic [1:0]                 nch_q, idx_q;
	logic [egd_pkg::DVAL_W-1:0] dval_q;
	logic                       derr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			nch_q       <= 2'd1;
			idx_q       <= 2'd0;
		end else if (ld_buf) begin
			buf_valid_q <= 1'b1;
			nch_q       <= nch_d;
			idx_q       <= 2'd0;
		end else if (m_fire) begin
			if (m_tlast) begin
				buf_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_buf) begin
			bch_q  <= c_d;
			dval_q <= enc_s2 ? '0 : egd_pkg::DVAL_W'(dval_s2);
			derr_q <= enc_s2 ? 1'b0 : derr_s2;
		end
	end

	assign m_tvalid = buf_valid_q;
	assign m_tlast  = (idx_q == nch_q - 2'd1);
	assign m_tdata  = {derr_q, dval_q, bch_q[idx_q].cnt, bch_q[idx_q].bits};

`ifndef NO_ASSERTIONS
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		buf_valid_q |-> (idx_q < nch_q))
		else $error("chunk index beyond chunk count");

	a_nch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		buf_valid_q |-> (nch_q != 2'd0))
		else $error("result buffer holds no chunk");

	a_val_left: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_VAL) |-> (left_q != '0))
		else $error("value phase with no bits left");

	a_last_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(m_fire && m_tlast && !ld_buf) |=> !buf_valid_q)
		else $error("buffer still valid after final transfer");

	a_next_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		(m_fire && !m_tlast) |=> (buf_valid_q && idx_q == $past(idx_q) + 2'd1))
		else $error("chunk index did not advance");
`endif

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for elias_gamma_delta_codec, encode chunks and decoded values
// checked against a local bit-level codec model; depends on rtl/egd_pkg.sv and the codec rtl
`timescale 1ns / 1ps

module tb_top;

	typedef enum logic [1:0] {PH_ONES, PH_LENGTH, PH_VALUE} dec_phase_t;

	typedef struct packed {
		logic [egd_pkg::CHUNK_W-1:0] code_bits;
		logic [egd_pkg::CNT_W-1:0]   bit_count;
		logic [egd_pkg::DVAL_W-1:0]  value;
		logic                        err;
		logic                        last;
	} result_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [2:0]                      paddr;
	logic [31:0]                     pwdata;
	logic [31:0]                     prdata;
	logic                            pready;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [egd_pkg::IN_TDATA_W-1:0]  s_tdata;  // value[63:0], in_bit[64], zero pad
	logic                            m_tvalid;
	logic                            m_tready;
	logic [egd_pkg::OUT_TDATA_W-1:0] m_tdata;  // code_bits[63:0], bit_count[70:64],
	                                           // decoded_value[134:71], error[135]
	logic                            m_tlast;

	// model state
	logic        cfg_dir;
	logic        cfg_kind;
	dec_phase_t  dec_phase;
	int          ones_cnt;
	int          bits_left;
	logic [6:0]  len_field;
	logic [63:0] bit_acc;
	int          decoded_cnt;

	result_t     awaited_results[$];
	result_t     got_res;
	result_t     want_res;
	int          errors;
	bit          idle_on;
	bit          hold_req;
	int          hold_left;

	elias_gamma_delta_codec u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [63:0] random64();
		return {$urandom, $urandom};
	endfunction

	function automatic int bit_length(input logic [63:0] v);
		int n;
		n = 1;
		for (int i = 1; i < 64; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	// whole code word right-aligned, first bit at position len-1
	function automatic void build_code(input logic [63:0] v, output logic [191:0] code,
			output int len);
		int z;
		int zl;
		z = bit_length(v);
		code = '0;
		if (cfg_kind == egd_pkg::KIND_DELTA) begin
			zl = bit_length(64'(z + 1));
			code = (192'd1 << zl) - 192'd1;
			code = code << 1;
			code = (code << zl) | 192'(z + 1);
			len = 2 * zl + 1;
		end else begin
			code = (192'd1 << z) - 192'd1;
			code = code << 1;
			len = z + 1;
		end
		code = (code << z) | 192'(v);
		len += z;
	endfunction

	function automatic void encode_chunks(input logic [63:0] v);
		logic [191:0] code;
		logic [191:0] part;
		logic [63:0]  mask;
		int           len;
		int           nres;
		int           cnt;
		result_t      r;
		build_code(v, code, len);
		nres = (len + 63) / 64;
		for (int k = 0; k < nres; k++) begin
			cnt = (len - 64 * k > 64) ? 64 : len - 64 * k;
			part = code >> (len - 64 * k - cnt);
			mask = (cnt == 64) ? {64{1'b1}} : ((64'd1 << cnt) - 64'd1);
			r.code_bits = part[63:0] & mask;
			r.bit_count = egd_pkg::CNT_W'(cnt);
			r.value = '0;
			r.err = 1'b0;
			r.last = (k == nres - 1);
			awaited_results.push_back(r);
		end
	endfunction

	function automatic void clear_decoder();
		dec_phase = PH_ONES;
		ones_cnt = 0;
		bits_left = 0;
		len_field = '0;
		bit_acc = '0;
	endfunction

	function automatic void push_decoded(input logic [63:0] v, input logic e);
		result_t r;
		r.code_bits = '0;
		r.bit_count = '0;
		r.value = e ? 64'd0 : v;
		r.err = e;
		r.last = 1'b1;
		awaited_results.push_back(r);
		decoded_cnt++;
		clear_decoder();
	endfunction

	function automatic void open_value(input int z);
		if (z == 0) begin
			push_decoded(64'd0, 1'b0);
		end else begin
			dec_phase = PH_VALUE;
			bits_left = z;
			bit_acc = '0;
		end
	endfunction

	function automatic void decode_bit(input logic b);
		int limit;
		case (dec_phase)
			PH_ONES: begin
				limit = (cfg_kind == egd_pkg::KIND_DELTA) ? bit_length(64'd65) : 64;
				if (b) begin
					if (ones_cnt + 1 > limit) push_decoded(64'd0, 1'b1);
					else ones_cnt++;
				end else if (cfg_kind == egd_pkg::KIND_GAMMA) begin
					open_value(ones_cnt);
				end else if (ones_cnt == 0) begin
					push_decoded(64'd0, 1'b1);
				end else begin
					dec_phase = PH_LENGTH;
					bits_left = ones_cnt;
					len_field = '0;
				end
			end
			PH_LENGTH: begin
				len_field = {len_field[5:0], b};
				if (bits_left > 0) bits_left--;
				if (bits_left == 0) begin
					if (len_field == 0 || int'(len_field) - 1 > 64)
						push_decoded(64'd0, 1'b1);
					else
						open_value(int'(len_field) - 1);
				end
			end
			PH_VALUE: begin
				bit_acc = {bit_acc[62:0], b};
				if (bits_left > 0) bits_left--;
				if (bits_left == 0) push_decoded(bit_acc, 1'b0);
			end
			default: clear_decoder();
		endcase
	endfunction

	task automatic write_reg(input logic idx, input logic val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {31'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == egd_pkg::REG_DIRECTION) cfg_dir = val;
		else cfg_kind = val;
		clear_decoder();
		@(posedge clk);
	endtask

	task automatic send_item(input logic [63:0] v, input logic b);
		while (idle_on && $urandom_range(0, 99) < 19) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, b, v};
		do @(posedge clk); while (!s_tready);
		if (cfg_dir == egd_pkg::DIR_DECODE) decode_bit(b);
		else encode_chunks(v);
	endtask

	task automatic send_bits(input logic [127:0] pat, input int n);
		for (int i = n - 1; i >= 0; i--)
			send_item(random64(), pat[i]);
	endtask

	// feed the code word of v bit by bit, optionally with one bit flipped
	task automatic send_code(input logic [63:0] v, input bit corrupt);
		logic [191:0] code;
		int           len;
		int           pos;
		build_code(v, code, len);
		if (corrupt) begin
			pos = $urandom_range(0, len - 1);
			code[pos] = ~code[pos];
		end
		for (int i = len - 1; i >= 0; i--)
			send_item(random64(), code[i]);
	endtask

	task automatic finish_phase();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic test_encode_directed();
		write_reg(egd_pkg::REG_DIRECTION, egd_pkg::DIR_ENCODE);
		write_reg(egd_pkg::REG_CODE_KIND, egd_pkg::KIND_GAMMA);
		send_item(64'd0, 1'b1);
		send_item(64'd1, 1'b0);
		send_item(64'h7FFF_FFFF, 1'b1);
		send_item(64'hFFFF_FFFF, 1'b0);
		send_item(64'h8000_0000_0000_0000, 1'b1);
		send_item({64{1'b1}}, 1'b0);
		finish_phase();
		write_reg(egd_pkg::REG_CODE_KIND, egd_pkg::KIND_DELTA);
		send_item(64'd0, 1'b0);
		send_item(64'd1, 1'b1);
		send_item(64'd5, 1'b0);
		send_item(64'h8000_0000, 1'b1);
		send_item({64{1'b1}}, 1'b1);
		finish_phase();
	endtask

	task automatic test_decode_special_cases();
		write_reg(egd_pkg::REG_DIRECTION, egd_pkg::DIR_DECODE);
		write_reg(egd_pkg::REG_CODE_KIND, egd_pkg::KIND_GAMMA);
		send_bits(128'b0, 1);
		send_bits(128'b101, 3);
		// length beyond the value width
		repeat (65) send_item(random64(), 1'b1);
		finish_phase();
		write_reg(egd_pkg::REG_CODE_KIND, egd_pkg::KIND_DELTA);
		send_bits(128'b0, 1);
		repeat (8) send_item(random64(), 1'b1);
		send_bits(128'b101, 3);
		send_bits(128'b100, 3);
		send_bits({7'h7F, 1'b0, 7'h7F}, 15);
		send_bits({7'h7F, 1'b0, 7'h42}, 15);
		send_code({64{1'b1}}, 1'b0);
		finish_phase();
	endtask

	task automatic test_config_clear();
		write_reg(egd_pkg::REG_DIRECTION, egd_pkg::DIR_DECODE);
		write_reg(egd_pkg::REG_CODE_KIND, egd_pkg::KIND_DELTA);
		send_bits(128'b11, 2);
		finish_phase();
		write_reg(egd_pkg::REG_CODE_KIND, egd_pkg::KIND_GAMMA);
		send_bits(128'b1, 1);
		finish_phase();
		write_reg(egd_pkg::REG_DIRECTION, egd_pkg::DIR_ENCODE);
		write_reg(egd_pkg::REG_DIRECTION, egd_pkg::DIR_DECODE);
		send_bits(128'b0, 1);
		finish_phase();
	endtask

	task automatic test_encode_random();
		logic [63:0] v;
		write_reg(egd_pkg::REG_DIRECTION, egd_pkg::DIR_ENCODE);
		for (int kind = 0; kind < 2; kind++) begin
			write_reg(egd_pkg::REG_CODE_KIND, kind[0]);
			// delta pass runs with no idling on either side
			idle_on = (kind[0] == egd_pkg::KIND_GAMMA);
			for (int i = 0; i < 25; i++) begin
				v = random64() >> $urandom_range(0, 63);
				if ($urandom_range(0, 19) == 0) v = '0;
				send_item(v, 1'($urandom_range(0, 1)));
			end
			finish_phase();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		write_reg(egd_pkg::REG_DIRECTION, egd_pkg::DIR_ENCODE);
		write_reg(egd_pkg::REG_CODE_KIND, egd_pkg::KIND_GAMMA);
		hold_req = 1'b1;
		for (int i = 0; i < 20; i++)
			send_item(random64(), 1'($urandom_range(0, 1)));
		finish_phase();
	endtask

	task automatic test_decode_random();
		logic [63:0] v;
		int          first;
		write_reg(egd_pkg::REG_DIRECTION, egd_pkg::DIR_DECODE);
		for (int kind = 0; kind < 2; kind++) begin
			write_reg(egd_pkg::REG_CODE_KIND, kind[0]);
			first = decoded_cnt;
			while (decoded_cnt - first < 3) begin
				if ($urandom_range(0, 99) < 6) v = random64() >> $urandom_range(0, 8);
				else v = 64'($urandom_range(0, 15));
				send_code(v, $urandom_range(0, 99) < 15);
			end
			repeat (10) send_item(random64(), 1'($urandom_range(0, 1)));
			finish_phase();
		end
	endtask

	// result sink with random stalls and one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= !(idle_on && $urandom_range(0, 99) < 19);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = {m_tdata[63:0], m_tdata[70:64], m_tdata[134:71], m_tdata[135], m_tlast};
			if (awaited_results.size() == 0) begin
				errors++;
				$display("%0t: transfer with nothing awaited, actual %h", $time, got_res);
			end else begin
				want_res = awaited_results.pop_front();
				if (got_res !== want_res) begin
					errors++;
					$display("%0t: expected bits=%h count=%0d value=%h error=%b last=%b",
						$time, want_res.code_bits, want_res.bit_count, want_res.value,
						want_res.err, want_res.last);
					$display("%0t: actual   bits=%h count=%0d value=%h error=%b last=%b",
						$time, got_res.code_bits, got_res.bit_count, got_res.value,
						got_res.err, got_res.last);
				end
			end
		end
	end

	initial begin
		errors = 0;
		decoded_cnt = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		hold_left = 0;
		cfg_dir = egd_pkg::DIR_ENCODE;
		cfg_kind = egd_pkg::KIND_DELTA;
		clear_decoder();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_directed();
		test_decode_special_cases();
		test_config_clear();
		test_encode_random();
		test_backpressure();
		test_decode_random();
		finish_phase();
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
